FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the mix accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never be true
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_IMPLY_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pmix_pkg.sv
// Types, constants and helper functions of the PCM mix accumulator.
package pmix_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int VOL_W      = 8;
   localparam int IDX_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int CONV_LAT   = 6;
   localparam int ROWMAP_LAT = 2;

   // floor(2^32 / 100): quotient estimate, off by at most one
   localparam logic [25:0] DIV100_RECIP = 26'd42949672;
   localparam logic [7:0]  DIVISOR      = 8'd100;
   // exact x / 100 for x below 2^15 as (x * 5243) >> 19
   localparam logic [12:0] REM_RECIP    = 13'd5243;
   localparam int          REM_SHIFT    = 19;

   localparam logic [7:0]  BYTE_MAX  = 8'hff;
   localparam logic [7:0]  BYTE_HALF = 8'h80;

   typedef enum logic [1:0] {
      OP_MIX      = 2'd0,
      OP_READ     = 2'd1,
      OP_READ_CLR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      WID_8  = 2'd0,
      WID_16 = 2'd1,
      WID_32 = 2'd2
   } wid_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH = 3'd0,
      CSR_DST_WIDTH = 3'd1,
      CSR_SRC_CH    = 3'd2,
      CSR_DST_CH    = 3'd3,
      CSR_SRC_VOL   = 3'd4
   } csr_type;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic [IDX_W-1:0]           frame_index;
      logic signed [SAMPLE_W-1:0] src_left;
      logic signed [SAMPLE_W-1:0] src_right;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] dst_left;
      logic signed [SAMPLE_W-1:0] dst_right;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]       src_width_code;
      logic [1:0]       dst_width_code;
      logic [VOL_W-1:0] src_volume;
   } conv_cfg_type;

   typedef struct packed {
      logic       vld;
      logic [1:0] op;
   } stage_type;

   function automatic logic [SAMPLE_W-1:0] width_mask(input logic [1:0] code);
      logic [SAMPLE_W-1:0] m;
      case (code)
         WID_8:   m = 32'h0000_00ff;
         WID_16:  m = 32'h0000_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [SAMPLE_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v,
                                                       input logic [1:0] code);
      logic [SAMPLE_W-1:0] r;
      case (code)
         WID_8:   r = {{24{v[7]}}, v[7:0]};
         WID_16:  r = {{16{v[15]}}, v[15:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/pcm_sample_mix_accumulator_top.sv
// Top level of the PCM mix accumulator: request pipeline, store access and result register.
//
// Usage:
//   req channel (valid/ready) carries one item: an operation (mix, read, read-clear),
//   a frame index and two source samples. rsp channel (valid/ready) returns one
//   item per request: the destination frame after the operation (before the clear
//   for read-clear), sign-extended from the destination width.
//   csr port: write enable, register index, 8-bit data; writes take effect at once
//   and the user must make them only while no item is in flight (not enforced here).
// Timing:
//   Throughput is one item per cycle unless stalled or clearing: each item reads its
//   frame row on the store's read port and, for mix and read-clear, writes it on the
//   write port, with the row just written forwarded to the next item.
// Reset:
//   Registers take their reset values, then a clearing pass writes zero to every
//   row, one row per cycle; req_ready stays low meanwhile.
// Stall:
//   When rsp_valid is high and rsp_ready low the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated.
`include "assert_macros.svh"

module pcm_sample_mix_accumulator_top #(
   parameter int FRAMES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pmix_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pmix_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_wr_en,
   input  logic [pmix_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pmix_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ROW_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ROW_PIPE = pmix_pkg::CONV_LAT - pmix_pkg::ROWMAP_LAT;
   localparam int LAST_STG = pmix_pkg::CONV_LAT - 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAMES - 1);

   // configuration
   logic [1:0] src_wid_ff;
   logic [1:0] dst_wid_ff;
   logic [1:0] src_ch_ff;
   logic [1:0] dst_ch_ff;
   logic [7:0] src_vol_ff;
   pmix_pkg::conv_cfg_type conv_cfg;

   // pipeline
   logic                  adv;
   logic                  req_acc;
   pmix_pkg::stage_type   stg_in;
   pmix_pkg::stage_type   stg_ff [0:pmix_pkg::CONV_LAT-1];
   logic [ROW_W-1:0]      map_row;
   logic [ROW_W-1:0]      row_pipe_ff [0:ROW_PIPE-1];
   logic [31:0]           lane1_in;
   logic [31:0]           add0;
   logic [31:0]           add1;

   // store access
   logic [63:0]      rd_data;
   logic [ROW_W-1:0] cur_row;
   logic [63:0]      old_row;
   logic [31:0]      old_l;
   logic [31:0]      old_r;
   logic [31:0]      dmask;
   logic             dst_two;
   logic [31:0]      mix_l;
   logic [31:0]      mix_r;
   logic [31:0]      new_l;
   logic [31:0]      new_r;
   logic [31:0]      out_l;
   logic [31:0]      out_r;
   logic             wr_need;
   logic             item_wr;
   logic             mem_wr_en;
   logic [ROW_W-1:0] mem_wr_addr;
   logic [63:0]      mem_wr_data;
   logic             fwd_vld_ff;
   logic [ROW_W-1:0] fwd_row_ff;
   logic [63:0]      fwd_data_ff;

   // clearing pass
   logic             clr_busy_ff;
   logic [ROW_W-1:0] clr_row_ff;

   // result register
   logic                      rsp_valid_ff;
   pmix_pkg::rsp_payload_type rsp_in;
   pmix_pkg::rsp_payload_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_wid_ff <= pmix_pkg::WID_16;
         dst_wid_ff <= pmix_pkg::WID_16;
         src_ch_ff  <= 2'd1;
         dst_ch_ff  <= 2'd1;
         src_vol_ff <= 8'd100;
      end else if (csr_wr_en) begin
         case (csr_index)
            pmix_pkg::CSR_SRC_WIDTH: src_wid_ff <= csr_wdata[1:0];
            pmix_pkg::CSR_DST_WIDTH: dst_wid_ff <= csr_wdata[1:0];
            pmix_pkg::CSR_SRC_CH:    src_ch_ff  <= csr_wdata[1:0];
            pmix_pkg::CSR_DST_CH:    dst_ch_ff  <= csr_wdata[1:0];
            pmix_pkg::CSR_SRC_VOL:   src_vol_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign conv_cfg.src_width_code = src_wid_ff;
   assign conv_cfg.dst_width_code = dst_wid_ff;
   assign conv_cfg.src_volume     = src_vol_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clr_busy_ff;
   assign req_acc   = req_valid && req_ready;

   assign stg_in.vld = req_acc;
   assign stg_in.op  = req_data.req_type;

   // channel count 0 acts as 1, 3 as 2
   assign lane1_in = src_ch_ff[1] ? req_data.src_right : req_data.src_left;
   assign dst_two  = dst_ch_ff[1];

   pmix_conv u_conv0 (
      .clock      (clock),
      .en         (adv),
      .cfg        (conv_cfg),
      .sample_in  (req_data.src_left),
      .sample_out (add0)
   );

   pmix_conv u_conv1 (
      .clock      (clock),
      .en         (adv),
      .cfg        (conv_cfg),
      .sample_in  (lane1_in),
      .sample_out (add1)
   );

   pmix_rowmap #(
      .FRAMES (FRAMES),
      .ROW_W  (ROW_W)
   ) u_rowmap (
      .clock (clock),
      .en    (adv),
      .idx   (req_data.frame_index),
      .row   (map_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pmix_pkg::CONV_LAT; k++) begin
            stg_ff[k].vld <= 1'b0;
            stg_ff[k].op  <= pmix_pkg::OP_READ;
         end
      end else if (adv) begin
         stg_ff[0] <= stg_in;
         for (int k = 1; k < pmix_pkg::CONV_LAT; k++) begin
            stg_ff[k] <= stg_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_pipe_ff[0] <= map_row;
         for (int k = 1; k < ROW_PIPE; k++) begin
            row_pipe_ff[k] <= row_pipe_ff[k-1];
         end
      end
   end

   pmix_store #(
      .DEPTH  (FRAMES),
      .ADDR_W (ROW_W),
      .DATA_W (64)
   ) u_store (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (row_pipe_ff[ROW_PIPE-2]),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign cur_row = row_pipe_ff[ROW_PIPE-1];
   // row written at the edge of our read is not in rd_data yet
   assign old_row = (fwd_vld_ff && (fwd_row_ff == cur_row)) ? fwd_data_ff : rd_data;
   assign old_l   = old_row[31:0];
   assign old_r   = old_row[63:32];
   assign dmask   = pmix_pkg::width_mask(dst_wid_ff);
   assign mix_l   = (old_l + add0) & dmask;
   assign mix_r   = dst_two ? ((old_r + add1) & dmask) : old_r;

   always_comb begin
      new_l   = old_l;
      new_r   = old_r;
      out_l   = old_l;
      out_r   = old_r;
      wr_need = 1'b0;
      case (stg_ff[LAST_STG].op)
         pmix_pkg::OP_MIX: begin
            new_l   = mix_l;
            new_r   = mix_r;
            out_l   = mix_l;
            out_r   = mix_r;
            wr_need = 1'b1;
         end
         pmix_pkg::OP_READ_CLR: begin
            new_l   = '0;
            new_r   = '0;
            wr_need = 1'b1;
         end
         default: ;
      endcase
   end

   assign item_wr     = adv && stg_ff[LAST_STG].vld && wr_need;
   assign mem_wr_en   = item_wr || clr_busy_ff;
   assign mem_wr_addr = clr_busy_ff ? clr_row_ff : cur_row;
   assign mem_wr_data = clr_busy_ff ? 64'd0 : {new_r, new_l};

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (adv) begin
         fwd_vld_ff <= item_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_row_ff  <= cur_row;
         fwd_data_ff <= {new_r, new_l};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == LAST_ROW) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign rsp_in.dst_left  = pmix_pkg::sext_sample(out_l, dst_wid_ff);
   assign rsp_in.dst_right = dst_two ? pmix_pkg::sext_sample(out_r, dst_wid_ff) : 32'sd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= stg_ff[LAST_STG].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && stg_ff[LAST_STG].vld) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEVER(a_wr_collide, clock, reset, item_wr && clr_busy_ff, "item write during clear")
   `ASSERT_IMPLY_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, stg_ff[0].vld, "accepted item lost")
   `ASSERT_IMPLY(a_clear_end, clock, reset, $fell(clr_busy_ff), $past(clr_row_ff) == LAST_ROW, "clear ended early")

endmodule

FILE: hw/rtl/pmix_conv.sv
// Sample conversion lane: sign extend, volume scale with divide by 100, width change.
module pmix_conv (
   input  logic                           clock,
   input  logic                           en,
   input  pmix_pkg::conv_cfg_type         cfg,
   input  logic [pmix_pkg::SAMPLE_W-1:0]  sample_in,
   output logic [pmix_pkg::SAMPLE_W-1:0]  sample_out
);

   // stage 1: magnitude and sign
   logic [31:0] sx;
   logic [31:0] mag1_in;
   logic [31:0] mag1_ff;
   logic        neg1_ff;

   // stage 2: quotient estimate
   logic [57:0] prod2;
   logic [25:0] qest2_ff;
   logic [31:0] mag2_ff;
   logic        neg2_ff;

   // stage 3: quotient and remainder by 100
   logic [31:0] qx100;
   logic [31:0] rem_raw;
   logic [25:0] q3_in;
   logic [6:0]  r3_in;
   logic [25:0] q3_ff;
   logic [6:0]  r3_ff;
   logic        neg3_ff;

   // stage 4: scale by volume
   logic [33:0] qv4_ff;
   logic [14:0] rv4_ff;
   logic        neg4_ff;

   // stage 5: remainder part and sum
   logic [27:0] rprod5;
   logic [33:0] mag5_in;
   logic [33:0] mag5_ff;
   logic        neg5_ff;

   // stage 6: sign and width change
   logic [31:0] s6;
   logic [15:0] sixteen;
   logic [7:0]  hi;
   logic [31:0] out6_in;
   logic [31:0] out6_ff;

   assign sx      = pmix_pkg::sext_sample(sample_in, cfg.src_width_code);
   assign mag1_in = sx[31] ? (~sx + 32'd1) : sx;

   assign prod2 = 58'(mag1_ff) * 58'(pmix_pkg::DIV100_RECIP);

   assign qx100   = ({6'd0, qest2_ff} << 6) + ({6'd0, qest2_ff} << 5) + ({6'd0, qest2_ff} << 2);
   assign rem_raw = mag2_ff - qx100;

   always_comb begin
      if (rem_raw[7:0] >= pmix_pkg::DIVISOR) begin
         q3_in = qest2_ff + 26'd1;
         r3_in = 7'(rem_raw[7:0] - pmix_pkg::DIVISOR);
      end else begin
         q3_in = qest2_ff;
         r3_in = rem_raw[6:0];
      end
   end

   assign rprod5  = 28'(rv4_ff) * 28'(pmix_pkg::REM_RECIP);
   assign mag5_in = qv4_ff + 34'(rprod5[27:pmix_pkg::REM_SHIFT]);

   assign s6      = neg5_ff ? (~mag5_ff[31:0] + 32'd1) : mag5_ff[31:0];
   assign sixteen = s6[15:0];

   always_comb begin
      hi      = sixteen[15:8];
      out6_in = s6;
      if ((cfg.src_width_code == pmix_pkg::WID_16) && (cfg.dst_width_code == pmix_pkg::WID_8)) begin
         if ((hi != pmix_pkg::BYTE_MAX) && (sixteen[7:0] > pmix_pkg::BYTE_HALF)) begin
            hi = hi + 8'd1;
         end
         out6_in = {24'd0, hi};
      end else if ((cfg.src_width_code == pmix_pkg::WID_8) &&
                   (cfg.dst_width_code == pmix_pkg::WID_16)) begin
         out6_in = s6[7] ? {16'd0, pmix_pkg::BYTE_MAX, s6[7:0]} : {24'd0, s6[7:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= sx[31];
         qest2_ff <= prod2[57:32];
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         q3_ff    <= q3_in;
         r3_ff    <= r3_in;
         neg3_ff  <= neg2_ff;
         qv4_ff   <= 34'(q3_ff) * 34'(cfg.src_volume);
         rv4_ff   <= 15'(r3_ff) * 15'(cfg.src_volume);
         neg4_ff  <= neg3_ff;
         mag5_ff  <= mag5_in;
         neg5_ff  <= neg4_ff;
         out6_ff  <= out6_in;
      end
   end

   assign sample_out = out6_ff;

endmodule

FILE: hw/rtl/pmix_rowmap.sv
// Frame index to store row: index modulo FRAMES by reciprocal estimate and one correction.
module pmix_rowmap #(
   parameter int FRAMES = 4096,
   parameter int ROW_W  = 12
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pmix_pkg::IDX_W-1:0]  idx,
   output logic [ROW_W-1:0]            row
);

   localparam int          RECIP_SHIFT = 24;
   localparam logic [24:0] ROW_RECIP   = 25'((1 << RECIP_SHIFT) / FRAMES);
   localparam logic [16:0] FRAMES_C    = 17'(FRAMES);

   logic [36:0] prod1;
   logic [11:0] qest1_ff;
   logic [11:0] idx1_ff;
   logic [28:0] fprod2;
   logic [28:0] rem2;
   logic [28:0] row2_in;
   logic [ROW_W-1:0] row2_ff;

   assign prod1   = 37'(idx) * 37'(ROW_RECIP);
   assign fprod2  = 29'(qest1_ff) * 29'(FRAMES_C);
   assign rem2    = 29'(idx1_ff) - fprod2;
   assign row2_in = (rem2 >= 29'(FRAMES_C)) ? (rem2 - 29'(FRAMES_C)) : rem2;

   always_ff @(posedge clock) begin
      if (en) begin
         qest1_ff <= prod1[35:24];
         idx1_ff  <= idx;
         row2_ff  <= row2_in[ROW_W-1:0];
      end
   end

   assign row = row2_ff;

endmodule

FILE: hw/rtl/pmix_store.sv
// Mix store: one row of two 32-bit entries per frame, registered read port, one write port.
module pmix_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] store_ff [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: dv/pcm_sample_mix_accumulator_top_tb.sv
// Testbench for pcm_sample_mix_accumulator_top: directed and random mixes checked against a frame-store predictor.
module pcm_sample_mix_accumulator_top_tb;

   localparam int FRAME_COUNT = 4096;
   localparam int HOLD_CYCLES = 200;
   localparam logic [1:0] OP_PLAIN_ALIAS = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pmix_pkg::req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pmix_pkg::rsp_payload_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [pmix_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pmix_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [31:0] frame_store [2*FRAME_COUNT];
   logic [1:0] cfg_src_w;
   logic [1:0] cfg_dst_w;
   logic [1:0] cfg_src_ch;
   logic [1:0] cfg_dst_ch;
   logic [7:0] cfg_vol;
   pmix_pkg::rsp_payload_type expected_frames [$];
   int mismatch_count = 0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;

   pcm_sample_mix_accumulator_top #(.FRAMES(FRAME_COUNT)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int width_bits(input logic [1:0] code);
      case (code)
         pmix_pkg::WID_8:  return 8;
         pmix_pkg::WID_16: return 16;
         default:          return 32;
      endcase
   endfunction

   function automatic int lanes(input logic [1:0] count);
      return count[1] ? 2 : 1;
   endfunction

   function automatic logic [31:0] sign_ext(input logic [31:0] v, input logic [1:0] code);
      int pad;
      pad = 32 - width_bits(code);
      return $signed(v << pad) >>> pad;
   endfunction

   // volume scaling, then the 16->8 / 8->16 depth conversion
   function automatic logic [31:0] scale_sample(input logic [31:0] raw);
      longint scaled;
      logic [31:0] s;
      logic [7:0] hi;
      scaled = longint'($signed(sign_ext(raw, cfg_src_w))) * longint'(cfg_vol) / 100;
      s = scaled[31:0];
      if (width_bits(cfg_src_w) == 16 && width_bits(cfg_dst_w) == 8) begin
         hi = s[15:8];
         if (hi != 8'hff && s[7:0] > 8'h80) hi = hi + 8'd1;
         s = {24'h0, hi};
      end else if (width_bits(cfg_src_w) == 8 && width_bits(cfg_dst_w) == 16) begin
         s = {16'h0, {8{s[7]}}, s[7:0]};
      end
      return s;
   endfunction

   function automatic pmix_pkg::rsp_payload_type mix_frame(
      input pmix_pkg::req_payload_type item);
      pmix_pkg::rsp_payload_type res;
      int row;
      int n_src;
      int n_dst;
      logic [31:0] keep;
      row = 2 * int'(item.frame_index);
      n_src = lanes(cfg_src_ch);
      n_dst = lanes(cfg_dst_ch);
      keep = 32'hffff_ffff >> (32 - width_bits(cfg_dst_w));
      if (item.req_type == pmix_pkg::OP_MIX) begin
         for (int ch = 0; ch < n_dst; ch++) begin
            frame_store[row+ch] = (frame_store[row+ch] + scale_sample(
               (ch == 1 && n_src == 2) ? item.src_right : item.src_left)) & keep;
         end
      end
      res.dst_left = sign_ext(frame_store[row], cfg_dst_w);
      res.dst_right = (n_dst == 2) ? sign_ext(frame_store[row+1], cfg_dst_w) : '0;
      if (item.req_type == pmix_pkg::OP_READ_CLR) begin
         frame_store[row] = '0;
         frame_store[row+1] = '0;
      end
      return res;
   endfunction

   function automatic logic [31:0] pick_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return {r[31:16], r[0] ? 16'h7fff : 16'h8000};
         3:       return {r[31:8], r[0] ? 8'h7f : 8'h80};
         4:       return {{24{r[7]}}, r[7:0]};
         default: return r;
      endcase
   endfunction

   // predictor and result check
   always @(posedge clock) begin
      pmix_pkg::rsp_payload_type want;
      if (reset) begin
         foreach (frame_store[i]) frame_store[i] = '0;
         cfg_src_w = pmix_pkg::WID_16;
         cfg_dst_w = pmix_pkg::WID_16;
         cfg_src_ch = 2'd1;
         cfg_dst_ch = 2'd1;
         cfg_vol = 8'd100;
         expected_frames.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               pmix_pkg::CSR_SRC_WIDTH: cfg_src_w = csr_wdata[1:0];
               pmix_pkg::CSR_DST_WIDTH: cfg_dst_w = csr_wdata[1:0];
               pmix_pkg::CSR_SRC_CH:    cfg_src_ch = csr_wdata[1:0];
               pmix_pkg::CSR_DST_CH:    cfg_dst_ch = csr_wdata[1:0];
               pmix_pkg::CSR_SRC_VOL:   cfg_vol = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_frames.push_back(mix_frame(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected item, expected none, got %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_data.dst_left !== want.dst_left) begin
                  $display("%0t: dst_left expected %h, got %h",
                           $time, want.dst_left, rsp_data.dst_left);
                  mismatch_count++;
               end
               if (rsp_data.dst_right !== want.dst_right) begin
                  $display("%0t: dst_right expected %h, got %h",
                           $time, want.dst_right, rsp_data.dst_right);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // result-side flow control, with one long hold-off requested by the backpressure test
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [11:0] frame,
                            input logic [31:0] left, input logic [31:0] right);
      int gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: op, frame_index: frame, src_left: left, src_right: right};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_frames.size() != 0);
   endtask

   task automatic write_reg(input pmix_pkg::csr_type idx, input logic [7:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] sw, input logic [7:0] dw,
                             input logic [7:0] sc, input logic [7:0] dc,
                             input logic [7:0] vol);
      wait_drained();
      write_reg(pmix_pkg::CSR_SRC_WIDTH, sw);
      write_reg(pmix_pkg::CSR_DST_WIDTH, dw);
      write_reg(pmix_pkg::CSR_SRC_CH, sc);
      write_reg(pmix_pkg::CSR_DST_CH, dc);
      write_reg(pmix_pkg::CSR_SRC_VOL, vol);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_config();
      set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)),
                 8'(($urandom_range(9) == 0) ? $urandom_range(201, 255)
                                             : $urandom_range(200)));
   endtask

   task automatic test_reset_state();
      send_item(pmix_pkg::OP_READ, 12'd0, 32'h0, 32'h0);
      send_item(pmix_pkg::OP_READ, 12'hfff, 32'hffff_ffff, 32'hffff_ffff);
   endtask

   task automatic test_accumulate_and_clear();
      send_item(pmix_pkg::OP_MIX, 12'hfff, 32'h0000_7fff, 32'h8000_0000);
      send_item(pmix_pkg::OP_MIX, 12'hfff, 32'hffff_0001, 32'h0);
      send_item(pmix_pkg::OP_READ_CLR, 12'hfff, 32'h0, 32'h0);
      send_item(pmix_pkg::OP_READ, 12'hfff, 32'h0, 32'h0);
   endtask

   task automatic test_volume_extremes();
      set_config(8'(pmix_pkg::WID_32), 8'(pmix_pkg::WID_32), 8'd2, 8'd2, 8'd200);
      send_item(pmix_pkg::OP_MIX, 12'd1, 32'h8000_0000, 32'h7fff_ffff);
      send_item(pmix_pkg::OP_READ_CLR, 12'd1, 32'h0, 32'h0);
   endtask

   task automatic test_width_conversion();
      set_config(8'(pmix_pkg::WID_16), 8'(pmix_pkg::WID_8), 8'd2, 8'd2, 8'd100);
      send_item(pmix_pkg::OP_MIX, 12'd2, 32'h0000_1281, 32'hffff_ff90);
      send_item(pmix_pkg::OP_MIX, 12'd3, 32'h0000_1280, 32'h0000_80ff);
      set_config(8'(pmix_pkg::WID_8), 8'(pmix_pkg::WID_16), 8'd1, 8'd2, 8'd100);
      send_item(pmix_pkg::OP_MIX, 12'd4, 32'h0000_0080, 32'h0000_007f);
   endtask

   // width code three, channel counts zero and three, volume above range, request code three
   task automatic test_odd_codes();
      set_config(8'h03, 8'hff, 8'h00, 8'h03, 8'd255);
      send_item(pmix_pkg::OP_MIX, 12'd5, 32'hffff_ffff, 32'h8000_0000);
      send_item(pmix_pkg::OP_MIX, 12'd5, 32'h7fff_ffff, 32'h0);
      send_item(OP_PLAIN_ALIAS, 12'd5, 32'h1234_5678, 32'h1234_5678);
   endtask

   task automatic test_mono_destination();
      set_config(8'(pmix_pkg::WID_16), 8'(pmix_pkg::WID_16), 8'd2, 8'd1, 8'd0);
      send_item(pmix_pkg::OP_MIX, 12'd6, 32'h0000_1234, 32'h0000_5678);
      set_config(8'(pmix_pkg::WID_16), 8'(pmix_pkg::WID_16), 8'd2, 8'd1, 8'd100);
      send_item(pmix_pkg::OP_MIX, 12'd6, 32'h0000_1234, 32'h0000_5678);
      set_config(8'(pmix_pkg::WID_16), 8'(pmix_pkg::WID_8), 8'd2, 8'd2, 8'd100);
      send_item(pmix_pkg::OP_READ, 12'd6, 32'h0, 32'h0);
      set_config(8'(pmix_pkg::WID_16), 8'(pmix_pkg::WID_16), 8'd2, 8'd1, 8'd100);
      send_item(pmix_pkg::OP_READ_CLR, 12'd6, 32'h0, 32'h0);
      set_config(8'(pmix_pkg::WID_16), 8'(pmix_pkg::WID_16), 8'd2, 8'd2, 8'd100);
      send_item(pmix_pkg::OP_READ, 12'd6, 32'h0, 32'h0);
   endtask

   // caller sets the first configuration; later blocks pick random ones
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int r;
      logic [1:0] op;
      logic [11:0] frame;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int blk = 0; blk < 4; blk++) begin
         if (blk != 0) random_config();
         repeat (32) begin
            r = $urandom_range(99);
            op = (r < 60) ? pmix_pkg::OP_MIX : (r < 78) ? pmix_pkg::OP_READ
                 : (r < 95) ? pmix_pkg::OP_READ_CLR : OP_PLAIN_ALIAS;
            frame = 12'(($urandom_range(3) != 0) ? $urandom_range(15)
                                                  : $urandom_range(4095));
            send_item(op, frame, pick_sample(), pick_sample());
         end
      end
   endtask

   task automatic test_backpressure();
      random_config();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req++;
      repeat (48) send_item(pmix_pkg::OP_MIX, 12'($urandom_range(7)), pick_sample(),
                            pick_sample());
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_accumulate_and_clear();
      test_volume_extremes();
      test_width_conversion();
      test_odd_codes();
      test_mono_destination();
      set_config(8'(pmix_pkg::WID_8), 8'(pmix_pkg::WID_8), 8'd2, 8'd2, 8'd200);
      test_random_traffic(0, 0);
      set_config(8'(pmix_pkg::WID_32), 8'(pmix_pkg::WID_32), 8'd2, 8'd2, 8'd0);
      test_random_traffic(56, 0);
      set_config(8'(pmix_pkg::WID_16), 8'(pmix_pkg::WID_8), 8'd2, 8'd2, 8'd200);
      test_random_traffic(0, 56);
      set_config(8'(pmix_pkg::WID_8), 8'(pmix_pkg::WID_16), 8'd1, 8'd2, 8'd255);
      test_random_traffic(15, 15);
      test_backpressure();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: pcm_sample_mix_accumulator_top.f
+incdir+hw/rtl
hw/rtl/pmix_pkg.sv
hw/rtl/pmix_conv.sv
hw/rtl/pmix_rowmap.sv
hw/rtl/pmix_store.sv
hw/rtl/pcm_sample_mix_accumulator_top.sv
dv/pcm_sample_mix_accumulator_top_tb.sv
